[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/blsd_pkg.sv]
// Types and constants of the button/lock scan debouncer.
// No dependencies.
`default_nettype none
package blsd_pkg;

  localparam int ButtonCount = 128;
  localparam int LockCount   = 40;
  localparam int SlotCount   = 5;
  localparam int LockIdxW    = $clog2(LockCount);
  localparam int SlotIdxW    = $clog2(SlotCount);

  localparam logic [7:0] LockOpenFlag = 8'h80;
  localparam logic [7:0] ButtonTicksReset = 8'd4;
  localparam logic [7:0] LockTicksReset = 8'd80;

  localparam logic CfgButtonTicks = 1'b0;
  localparam logic CfgLockTicks   = 1'b1;

  typedef enum logic [2:0] {
    ModeTick       = 3'd0,
    ModeScanStart  = 3'd1,
    ModeButtonBit  = 3'd2,
    ModeLockBit    = 3'd3,
    ModeClearBtn   = 3'd4,
    ModeClearLock  = 3'd5,
    ModeSetLockExp = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    PassNone   = 2'd0,
    PassDetect = 2'd1,
    PassCommit = 2'd2
  } pass_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] position;
    logic       level;
  } in_item_t;

  typedef struct packed {
    logic       recorded;
    logic       event_is_lock;
    logic [7:0] event_code;
    logic [2:0] slot_used;
    logic       settle_pending;
    logic       button_store_full;
    logic       lock_store_full;
  } out_item_t;

endpackage
`default_nettype wire

[rtl/button_lock_scan_debouncer_unit.sv]
// Button/lock scan debouncer: settle countdown, slot stores and lock-open bits.
// Depends on blsd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Takes one scanned item per cycle while in_stall is low and returns one
// registered result per item. The rate is one item per clock when not stalled:
// every state update (the countdown, the first-free search over the five slots
// of each store and the lock-open bit vector) finishes in the cycle of the
// transfer. A two-entry output stage (result register plus skid register)
// takes one more item while the result side stalls; in_stall rises only when
// both entries hold results. Configuration writes take effect at once.
module button_lock_scan_debouncer_unit
  import blsd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  logic [7:0] btn_ticks_r, lock_ticks_r;
  logic       pending_r, pending_nxt;
  logic [7:0] count_r, count_nxt;
  pass_t      pass_r, pass_nxt;
  logic       bstop_r, bstop_nxt, lstop_r, lstop_nxt;
  logic [7:0] bslots_r [SlotCount];
  logic [7:0] bslots_nxt [SlotCount];
  logic [7:0] lslots_r [SlotCount];
  logic [7:0] lslots_nxt [SlotCount];
  logic [LockCount-1:0] lopen_r, lopen_nxt;

  logic      out_valid_r, skid_v_r;
  out_item_t out_data_r, skid_data_r, res;
  logic      accept, out_fire;

  logic [SlotIdxW-1:0] bfree_idx, lfree_idx;
  logic                bfree_hit, lfree_hit;
  logic [7:0]          pos;
  logic                btn_ok, lock_ok, lock_bit, lock_change;
  logic [LockIdxW-1:0] lock_idx;
  logic [7:0]          lock_code;
  logic                bfull, lfull;

  assign accept    = in_valid && !skid_v_r;
  assign in_stall  = skid_v_r;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pos         = in_data.position;
  assign btn_ok      = (pos != 8'd0) && (pos <= 8'(ButtonCount)) && !in_data.level;
  assign lock_ok     = (pos != 8'd0) && (pos <= 8'(LockCount));
  assign lock_idx    = LockIdxW'(pos - 8'd1);
  assign lock_bit    = lock_ok ? lopen_r[lock_idx] : 1'b0;
  assign lock_change = lock_ok && (in_data.level == lock_bit);
  assign lock_code   = in_data.level ? pos : (pos | LockOpenFlag);

  always_comb begin
    bfree_idx = '0;
    bfree_hit = 1'b0;
    lfree_idx = '0;
    lfree_hit = 1'b0;
    for (int k = SlotCount - 1; k >= 0; k--) begin
      if (bslots_r[k] == 8'd0) begin
        bfree_idx = SlotIdxW'(k);
        bfree_hit = 1'b1;
      end
      if (lslots_r[k] == 8'd0) begin
        lfree_idx = SlotIdxW'(k);
        lfree_hit = 1'b1;
      end
    end
  end

  always_comb begin
    pending_nxt = pending_r;
    count_nxt   = count_r;
    pass_nxt    = pass_r;
    bstop_nxt   = bstop_r;
    lstop_nxt   = lstop_r;
    bslots_nxt  = bslots_r;
    lslots_nxt  = lslots_r;
    lopen_nxt   = lopen_r;
    res         = '0;
    if (accept) begin
      case (mode_t'(in_data.mode))
        ModeTick: begin
          if (count_r != 8'd0) count_nxt = count_r - 8'd1;
        end
        ModeScanStart: begin
          bstop_nxt = 1'b0;
          lstop_nxt = 1'b0;
          if (!pending_r) begin
            pass_nxt = PassDetect;
          end else if (count_r == 8'd0) begin
            pending_nxt = 1'b0;
            pass_nxt    = PassCommit;
          end else begin
            pass_nxt = PassNone;
          end
        end
        ModeButtonBit: begin
          if (btn_ok && pass_r == PassDetect) begin
            pending_nxt = 1'b1;
            count_nxt   = btn_ticks_r;
          end else if (btn_ok && pass_r == PassCommit && !bstop_r) begin
            if (bfree_hit) begin
              bslots_nxt[bfree_idx] = pos;
              res.recorded   = 1'b1;
              res.event_code = pos;
              res.slot_used  = 3'(bfree_idx);
            end else begin
              bstop_nxt = 1'b1;
            end
          end
        end
        ModeLockBit: begin
          if (lock_change && pass_r == PassDetect) begin
            pending_nxt = 1'b1;
            count_nxt   = lock_ticks_r;
          end else if (lock_change && pass_r == PassCommit && !lstop_r) begin
            if (lfree_hit) begin
              lslots_nxt[lfree_idx] = lock_code;
              lopen_nxt[lock_idx]   = ~in_data.level;
              res.recorded      = 1'b1;
              res.event_is_lock = 1'b1;
              res.event_code    = lock_code;
              res.slot_used     = 3'(lfree_idx);
            end else begin
              lstop_nxt = 1'b1;
            end
          end
        end
        ModeClearBtn: begin
          if (pos < 8'(SlotCount)) bslots_nxt[SlotIdxW'(pos)] = 8'd0;
        end
        ModeClearLock: begin
          if (pos < 8'(SlotCount)) lslots_nxt[SlotIdxW'(pos)] = 8'd0;
        end
        ModeSetLockExp: begin
          if (lock_ok) lopen_nxt[lock_idx] = in_data.level;
        end
        default: begin
        end
      endcase
    end
    bfull = 1'b1;
    lfull = 1'b1;
    for (int k = 0; k < SlotCount; k++) begin
      if (bslots_nxt[k] == 8'd0) bfull = 1'b0;
      if (lslots_nxt[k] == 8'd0) lfull = 1'b0;
    end
    res.settle_pending    = pending_nxt;
    res.button_store_full = bfull;
    res.lock_store_full   = lfull;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_ticks_r  <= ButtonTicksReset;
      lock_ticks_r <= LockTicksReset;
      pending_r    <= 1'b0;
      count_r      <= 8'd0;
      pass_r       <= PassNone;
      bstop_r      <= 1'b0;
      lstop_r      <= 1'b0;
      lopen_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_v_r     <= 1'b0;
      for (int k = 0; k < SlotCount; k++) begin
        bslots_r[k] <= 8'd0;
        lslots_r[k] <= 8'd0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgButtonTicks) btn_ticks_r <= cfg_wdata;
        if (cfg_index == CfgLockTicks) lock_ticks_r <= cfg_wdata;
      end
      pending_r <= pending_nxt;
      count_r   <= count_nxt;
      pass_r    <= pass_nxt;
      bstop_r   <= bstop_nxt;
      lstop_r   <= lstop_nxt;
      lopen_r   <= lopen_nxt;
      bslots_r  <= bslots_nxt;
      lslots_r  <= lslots_nxt;
      if (!out_valid_r || out_fire) begin
        out_valid_r <= skid_v_r || accept;
        skid_v_r    <= 1'b0;
      end else if (accept) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      out_data_r <= skid_v_r ? skid_data_r : res;
    end else if (accept) begin
      skid_data_r <= res;
    end
  end

  `ASSERT_ALWAYS(a_skid_needs_out, clk, rst_n, !skid_v_r || out_valid_r,
                 "skid entry held without a result in the output register")
  `ASSERT_ALWAYS(a_idle_fields_zero, clk, rst_n,
                 !(out_valid_r && !out_data_r.recorded) ||
                 (out_data_r.event_code == 8'd0 && out_data_r.slot_used == 3'd0 &&
                  !out_data_r.event_is_lock),
                 "event fields not zero on a result without a record")
  `ASSERT_ALWAYS(a_slot_range, clk, rst_n,
                 !(out_valid_r && out_data_r.recorded) ||
                 (out_data_r.slot_used < 3'(SlotCount)),
                 "recorded slot index beyond the store")
  `ASSERT_NEXT(a_stall_to_skid, clk, rst_n,
               accept && out_valid_r && out_stall, skid_v_r,
               "transfer during output stall not held in the skid register")

endmodule
`default_nettype wire
